FILE: sv/assert_macros.svh
// Assertion macros shared by the heap sort engine RTL.
// Every macro samples on the rising clock and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop holds at every sampled edge
`define HSE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// cons holds in the same cycle as ante
`define HSE_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// cons holds in the cycle after ante
`define HSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/hse_pkg.sv
// Package for the heap sort engine: constants, FSM states and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package hse_pkg;

    localparam int HSE_DEPTH      = 64;
    localparam int HSE_DATA_WIDTH = 32;
    localparam int HSE_VALUE_W    = 32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_BUILD_RD,
        ST_BUILD_LD,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_EXT_RD,
        ST_EXT_SWAP,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef enum logic [1:0] {
        PH_LOADING,
        PH_BUILDING,
        PH_EXTRACTING,
        PH_EMITTING
    } phase_t;

    // read address selection for the two RAM read ports
    typedef enum logic [1:0] {
        RD_PARENT,  // a: build parent
        RD_KIDS,    // a: left child, b: right child
        RD_EXT,     // a: root, b: heap tail
        RD_EMIT     // a: emit index
    } rd_sel_t;

    typedef struct packed {
        logic    load_beat;
        logic    build_init;
        logic    build_load;
        logic    ext_init;
        logic    ext_swap;
        logic    sift_step;
        logic    iter_dec;
        logic    emit_init;
        logic    emit_next;
        logic    out_load;
        logic    finish;
        rd_sel_t rd_sel;
    } cmd_t;

    typedef struct packed {
        logic iter_zero;
        logic iter_le1;
        logic sift_stop;
        logic emit_last;
    } sts_t;

endpackage

FILE: sv/hse_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: sv/hse_datapath.sv
// Heap sort datapath: element store, counters, sift compare and output register.
// Depends on hse_pkg, hse_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hse_datapath #(
    parameter int DEPTH      = hse_pkg::HSE_DEPTH,
    parameter int DATA_WIDTH = hse_pkg::HSE_DATA_WIDTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  hse_pkg::cmd_t                         cmd,
    output hse_pkg::sts_t                         sts,
    input  logic signed [hse_pkg::HSE_VALUE_W-1:0] s_value,
    output logic signed [hse_pkg::HSE_VALUE_W-1:0] m_sorted_value,
    output logic                                  m_end_of_run,
    output logic                                  m_overflow
);
    import hse_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = AW + 2;
    localparam int DW = DATA_WIDTH;
    localparam int VW = HSE_VALUE_W;

    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] iter_reg, iter_next;
    logic [CW-1:0] end_reg, end_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic          dropped_reg, dropped_next;
    logic [DW-1:0] pos_val_reg, pos_val_next;
    logic [VW-1:0] out_value_reg;
    logic          out_eor_reg;
    logic          out_ovf_reg;

    logic [DW-1:0] in_data;
    logic [VW-1:0] out_data;
    logic [DW-1:0] rd_a, rd_b;
    logic [AW-1:0] raddr_a, raddr_b;
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic          full;
    logic [CW-1:0] iter_m1;
    logic [KW-1:0] left_idx, right_idx, top_idx;
    logic          take_l, take_r, sift_stop;
    logic [DW-1:0] lv, big;

    // narrow or sign-extend the 32-bit input to the store width, and back
    generate
        if (DW <= VW) begin : g_in_narrow
            assign in_data = s_value[DW-1:0];
        end else begin : g_in_wide
            assign in_data = {{(DW-VW){s_value[VW-1]}}, s_value};
        end
        if (DW >= VW) begin : g_out_narrow
            assign out_data = rd_a[VW-1:0];
        end else begin : g_out_wide
            assign out_data = {{(VW-DW){rd_a[DW-1]}}, rd_a};
        end
    endgenerate

    assign full      = (fill_reg == CW'(DEPTH));
    assign iter_m1   = iter_reg - CW'(1);
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + KW'(1);

    // pick the largest of parent (held in pos_val) and its children in the heap
    always_comb begin
        take_l  = (left_idx < KW'(end_reg)) && ($signed(rd_a) > $signed(pos_val_reg));
        lv      = take_l ? rd_a : pos_val_reg;
        take_r  = (right_idx < KW'(end_reg)) && ($signed(rd_b) > $signed(lv));
        big     = take_r ? rd_b : lv;
        top_idx = take_r ? right_idx : (take_l ? left_idx : KW'(pos_reg));
        sift_stop = !take_l && !take_r;
    end

    always_comb begin
        unique case (cmd.rd_sel)
            RD_PARENT: begin
                raddr_a = iter_m1[AW-1:0];
                raddr_b = iter_m1[AW-1:0];
            end
            RD_KIDS: begin
                raddr_a = left_idx[AW-1:0];
                raddr_b = right_idx[AW-1:0];
            end
            RD_EXT: begin
                raddr_a = '0;
                raddr_b = iter_m1[AW-1:0];
            end
            RD_EMIT: begin
                raddr_a = iter_reg[AW-1:0];
                raddr_b = iter_reg[AW-1:0];
            end
            default: begin
                raddr_a = '0;
                raddr_b = '0;
            end
        endcase
    end

    // the sifted value rides in pos_val and is written back once it settles
    always_comb begin
        we    = 1'b0;
        waddr = pos_reg;
        wdata = pos_val_reg;
        priority if (cmd.load_beat) begin
            we    = !full;
            waddr = fill_reg[AW-1:0];
            wdata = in_data;
        end else if (cmd.sift_step) begin
            we    = 1'b1;
            waddr = pos_reg;
            wdata = sift_stop ? pos_val_reg : big;
        end else if (cmd.ext_swap) begin
            we    = 1'b1;
            waddr = iter_m1[AW-1:0];
            wdata = rd_a;
        end else begin
            we    = 1'b0;
        end
    end

    hse_ram #(
        .WIDTH(DW),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk   (aclk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr_a(raddr_a),
        .raddr_b(raddr_b),
        .rdata_a(rd_a),
        .rdata_b(rd_b)
    );

    always_comb begin
        fill_next    = fill_reg;
        iter_next    = iter_reg;
        end_next     = end_reg;
        pos_next     = pos_reg;
        dropped_next = dropped_reg;
        pos_val_next = pos_val_reg;
        if (cmd.load_beat) begin
            if (full) begin
                dropped_next = 1'b1;
            end else begin
                fill_next = fill_reg + CW'(1);
            end
        end
        if (cmd.build_init) begin
            iter_next = fill_reg >> 1;
        end
        if (cmd.ext_init) begin
            iter_next = fill_reg;
        end
        if (cmd.build_load) begin
            pos_next     = iter_m1[AW-1:0];
            pos_val_next = rd_a;
            end_next     = fill_reg;
        end
        if (cmd.ext_swap) begin
            pos_next     = '0;
            pos_val_next = rd_b;
            end_next     = iter_m1;
        end
        if (cmd.sift_step && !sift_stop) begin
            pos_next = top_idx[AW-1:0];
        end
        if (cmd.iter_dec) begin
            iter_next = iter_m1;
        end
        if (cmd.emit_init) begin
            iter_next = '0;
        end
        if (cmd.emit_next) begin
            iter_next = iter_reg + CW'(1);
        end
        if (cmd.finish) begin
            fill_next    = '0;
            iter_next    = '0;
            end_next     = '0;
            pos_next     = '0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            iter_reg    <= '0;
            end_reg     <= '0;
            pos_reg     <= '0;
            dropped_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            iter_reg    <= iter_next;
            end_reg     <= end_next;
            pos_reg     <= pos_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_val_reg <= pos_val_next;
        if (cmd.out_load) begin
            out_value_reg <= out_data;
            out_eor_reg   <= sts.emit_last;
            out_ovf_reg   <= dropped_reg;
        end
    end

    assign sts.iter_zero = (iter_reg == '0);
    assign sts.iter_le1  = (iter_reg <= CW'(1));
    assign sts.sift_stop = sift_stop;
    assign sts.emit_last = (iter_reg == fill_reg - CW'(1));

    assign m_sorted_value = out_value_reg;
    assign m_end_of_run   = out_eor_reg;
    assign m_overflow     = out_ovf_reg;

    `HSE_ASSERT_NEXT(a_sift_descends, aclk, aresetn, cmd.sift_step && !sift_stop, pos_reg > $past(pos_reg))
    `HSE_ASSERT_NEXT(a_drop_flagged, aclk, aresetn, cmd.load_beat && full, dropped_reg)
    `HSE_ASSERT_NEXT(a_build_end, aclk, aresetn, cmd.build_load, end_reg == fill_reg)

endmodule

FILE: sv/hse_ctrl.sv
// Heap sort controller: sequences loading, heap build, extraction and emit.
// Depends on hse_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hse_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_last,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output hse_pkg::cmd_t cmd,
    input  hse_pkg::sts_t sts
);
    import hse_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid && s_last) begin
                    state_next = ST_INIT;
                    phase_next = PH_BUILDING;
                end
            end
            ST_INIT: begin
                state_next = ST_BUILD_RD;
            end
            ST_BUILD_RD: begin
                if (sts.iter_zero) begin
                    state_next = ST_EXT_RD;
                    phase_next = PH_EXTRACTING;
                end else begin
                    state_next = ST_BUILD_LD;
                end
            end
            ST_BUILD_LD: begin
                state_next = ST_SIFT_RD;
            end
            ST_SIFT_RD: begin
                state_next = ST_SIFT_CMP;
            end
            ST_SIFT_CMP: begin
                if (!sts.sift_stop) begin
                    state_next = ST_SIFT_RD;
                end else if (phase_reg == PH_EXTRACTING) begin
                    state_next = ST_EXT_RD;
                end else begin
                    state_next = ST_BUILD_RD;
                end
            end
            ST_EXT_RD: begin
                if (sts.iter_le1) begin
                    state_next = ST_EMIT_RD;
                    phase_next = PH_EMITTING;
                end else begin
                    state_next = ST_EXT_SWAP;
                end
            end
            ST_EXT_SWAP: begin
                state_next = ST_SIFT_RD;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    if (sts.emit_last) begin
                        state_next = ST_LOAD;
                        phase_next = PH_LOADING;
                    end else begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
                phase_next = PH_LOADING;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd        = '0;
        cmd.rd_sel = RD_EMIT;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready       = 1'b1;
                cmd.load_beat = s_valid;
            end
            ST_INIT: begin
                cmd.build_init = 1'b1;
            end
            ST_BUILD_RD: begin
                if (sts.iter_zero) begin
                    cmd.ext_init = 1'b1;
                end else begin
                    cmd.rd_sel = RD_PARENT;
                end
            end
            ST_BUILD_LD: begin
                cmd.build_load = 1'b1;
            end
            ST_SIFT_RD: begin
                cmd.rd_sel = RD_KIDS;
            end
            ST_SIFT_CMP: begin
                cmd.rd_sel    = RD_KIDS;
                cmd.sift_step = 1'b1;
                cmd.iter_dec  = sts.sift_stop;
            end
            ST_EXT_RD: begin
                if (sts.iter_le1) begin
                    cmd.emit_init = 1'b1;
                end else begin
                    cmd.rd_sel = RD_EXT;
                end
            end
            ST_EXT_SWAP: begin
                cmd.rd_sel   = RD_EXT;
                cmd.ext_swap = 1'b1;
            end
            ST_EMIT_RD: begin
                cmd.rd_sel = RD_EMIT;
            end
            ST_EMIT_LD: begin
                cmd.rd_sel = RD_EMIT;
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.finish    = sts.emit_last;
                    cmd.emit_next = !sts.emit_last;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            phase_reg   <= PH_LOADING;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `HSE_ASSERT_SAME(a_load_free, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready)
    `HSE_ASSERT_NEXT(a_last_stops_input, aclk, aresetn, s_valid && s_ready && s_last, !s_ready)
    `HSE_ASSERT_NEXT(a_final_beat_reloads, aclk, aresetn, cmd.out_load && sts.emit_last, state_reg == ST_LOAD && m_valid)
    `HSE_ASSERT_SAME(a_emit_phase, aclk, aresetn, cmd.out_load, phase_reg == PH_EMITTING)

endmodule

FILE: sv/heap_sort_engine.sv
// Heap sort engine top level: controller plus datapath.
// Depends on hse_pkg, hse_ctrl, hse_datapath (and through it hse_ram).
//
// Collects signed values, one per input beat, into a DEPTH-entry store until a
// beat with s_last arrives, then heap-sorts the store in place and streams the
// values out in ascending order, m_end_of_run on the final one and m_overflow on
// every result of a set that lost beats to a full store. Input is held off
// (s_ready low) from the last beat until the final result sits in the output
// register. Loading accepts one beat per cycle. Sorting runs through one RAM with
// one write and two read ports: every sift level is a child read followed by a
// compare/write, each build parent adds a parent read and load, and each
// extraction adds a root/tail read and a swap; emitting reads each result and
// then loads it into the output register, waiting while that register is full.
`timescale 1ns / 1ps

module heap_sort_engine #(
    parameter int DEPTH      = hse_pkg::HSE_DEPTH,
    parameter int DATA_WIDTH = hse_pkg::HSE_DATA_WIDTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [hse_pkg::HSE_VALUE_W-1:0] s_value,
    input  logic                                   s_last,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [hse_pkg::HSE_VALUE_W-1:0] m_sorted_value,
    output logic                                   m_end_of_run,
    output logic                                   m_overflow
);
    import hse_pkg::*;

    cmd_t cmd;
    sts_t sts;

    hse_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_last (s_last),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .sts    (sts)
    );

    hse_datapath #(
        .DEPTH     (DEPTH),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_value       (s_value),
        .m_sorted_value(m_sorted_value),
        .m_end_of_run  (m_end_of_run),
        .m_overflow    (m_overflow)
    );

endmodule
